[src/mtd_pkg.sv]
// package for the morse text decoder: character codes, result type and code table
package mtd_pkg;

    localparam int unsigned CharW    = 8;
    localparam int unsigned LetterW  = 7;
    localparam int unsigned BitsW    = 5;
    localparam int unsigned CountW   = 3;
    localparam int unsigned MaxSyms  = 5;

    localparam logic [CharW-1:0] ChDot   = 8'd46;
    localparam logic [CharW-1:0] ChDash  = 8'd45;
    localparam logic [CharW-1:0] ChSpace = 8'd32;
    localparam logic [CharW-1:0] ChTab   = 8'd9;
    localparam logic [CharW-1:0] ChCr    = 8'd13;

    localparam logic [LetterW-1:0] NoLetter = '0;

    typedef struct packed {
        logic               has_letter;
        logic [LetterW-1:0] letter;
        logic               bad_code;
        logic               last;
    } result_t;

    // returns the letter for a token, or NoLetter when the pattern has no entry
    function automatic logic [LetterW-1:0] lookup(input logic [CountW-1:0] count,
                                                  input logic [BitsW-1:0]  bits);
        logic [LetterW-1:0] ch;
        ch = NoLetter;
        case (count)
            3'd1: begin
                case (bits)
                    5'd0:    ch = 7'("E");
                    5'd1:    ch = 7'("T");
                    default: ch = NoLetter;
                endcase
            end
            3'd2: begin
                case (bits)
                    5'd0:    ch = 7'("I");
                    5'd1:    ch = 7'("A");
                    5'd2:    ch = 7'("N");
                    5'd3:    ch = 7'("M");
                    default: ch = NoLetter;
                endcase
            end
            3'd3: begin
                case (bits)
                    5'd0:    ch = 7'("S");
                    5'd1:    ch = 7'("U");
                    5'd2:    ch = 7'("R");
                    5'd3:    ch = 7'("W");
                    5'd4:    ch = 7'("D");
                    5'd5:    ch = 7'("K");
                    5'd6:    ch = 7'("G");
                    5'd7:    ch = 7'("O");
                    default: ch = NoLetter;
                endcase
            end
            3'd4: begin
                case (bits)
                    5'd0:    ch = 7'("H");
                    5'd1:    ch = 7'("V");
                    5'd2:    ch = 7'("F");
                    5'd4:    ch = 7'("L");
                    5'd6:    ch = 7'("P");
                    5'd7:    ch = 7'("J");
                    5'd8:    ch = 7'("B");
                    5'd9:    ch = 7'("X");
                    5'd10:   ch = 7'("C");
                    5'd11:   ch = 7'("Y");
                    5'd12:   ch = 7'("Z");
                    5'd13:   ch = 7'("Q");
                    default: ch = NoLetter;
                endcase
            end
            3'd5: begin
                case (bits)
                    5'd0:    ch = 7'("5");
                    5'd1:    ch = 7'("4");
                    5'd3:    ch = 7'("3");
                    5'd7:    ch = 7'("2");
                    5'd15:   ch = 7'("1");
                    5'd16:   ch = 7'("6");
                    5'd24:   ch = 7'("7");
                    5'd28:   ch = 7'("8");
                    5'd30:   ch = 7'("9");
                    5'd31:   ch = 7'("0");
                    default: ch = NoLetter;
                endcase
            end
            default: ch = NoLetter;
        endcase
        return ch;
    endfunction

endpackage

[src/morse_text_decoder_unit.sv]
// morse text decoder: token assembly, table lookup and two-entry result buffer
// a result is registered into the output slot, or into the skid slot while the output slot is held
// throughput: one word per cycle; the input stalls only when both result slots are full
// the symbol shift, count and code table lookup are all combinational, in front of the result register
// reset: aresetn low clears the open token, the skip flag and both result slots
module morse_text_decoder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] letter, [7] zero
    output logic [1:0] m_tuser,   // [0] has_letter, [1] bad_code
    output logic       m_tlast    // last
);
    import mtd_pkg::*;

    logic [BitsW-1:0]  bits_reg, bits_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              inv_reg, inv_next;
    logic              failed_reg, failed_next;

    result_t out_reg, skid_reg, res;
    logic    out_v_reg, skid_v_reg;

    logic              accept, push, pop;
    logic              ws, sym, eom;
    logic [BitsW-1:0]  bits_a;
    logic [CountW-1:0] count_a;
    logic              inv_a;
    logic [LetterW-1:0] ch;

    assign s_tready = !skid_v_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_v_reg && m_tready;

    assign eom = s_tlast;
    assign ws  = (s_tdata == ChSpace) || (s_tdata >= ChTab && s_tdata <= ChCr);
    assign sym = (s_tdata == ChDot) || (s_tdata == ChDash);

    always_comb begin
        bits_next   = bits_reg;
        count_next  = count_reg;
        inv_next    = inv_reg;
        failed_next = failed_reg;
        push        = 1'b0;
        res         = '0;
        bits_a      = bits_reg;
        count_a     = count_reg;
        inv_a       = inv_reg;
        ch          = NoLetter;

        // symbol step
        if (sym) begin
            if (count_reg >= CountW'(MaxSyms)) begin
                inv_a = 1'b1;
            end else begin
                bits_a  = {bits_reg[BitsW-2:0], (s_tdata == ChDash)};
                count_a = count_reg + 1'b1;
            end
        end else if (!ws) begin
            inv_a = 1'b1;
        end

        if (failed_reg) begin
            // skipping the rest of a failed message
            if (eom) begin
                bits_next   = '0;
                count_next  = '0;
                inv_next    = 1'b0;
                failed_next = 1'b0;
            end
        end else if (!(ws || eom)) begin
            bits_next  = bits_a;
            count_next = count_a;
            inv_next   = inv_a;
        end else if (!inv_a && count_a == '0) begin
            // empty token; end of message still gets a marker
            bits_next  = '0;
            count_next = '0;
            inv_next   = 1'b0;
            if (eom) begin
                push     = 1'b1;
                res.last = 1'b1;
            end
        end else begin
            if (!inv_a) begin
                ch = lookup(count_a, bits_a);
            end
            bits_next  = '0;
            count_next = '0;
            inv_next   = 1'b0;
            push       = 1'b1;
            if (ch == NoLetter) begin
                failed_next  = !eom;
                res.bad_code = 1'b1;
                res.last     = 1'b1;
            end else begin
                res.has_letter = 1'b1;
                res.letter     = ch;
                res.last       = eom;
            end
        end

        if (!accept) begin
            push = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg   <= '0;
            count_reg  <= '0;
            inv_reg    <= 1'b0;
            failed_reg <= 1'b0;
        end else if (accept) begin
            bits_reg   <= bits_next;
            count_reg  <= count_next;
            inv_reg    <= inv_next;
            failed_reg <= failed_next;
        end
    end

    // output slot plus skid slot; push only happens while the skid slot is empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (!out_v_reg) begin
                out_v_reg <= push;
            end else if (pop) begin
                if (skid_v_reg) begin
                    skid_v_reg <= 1'b0;
                end else begin
                    out_v_reg <= push;
                end
            end else if (push) begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || (pop && !skid_v_reg)) begin
            out_reg <= res;
        end else if (pop) begin
            out_reg <= skid_reg;
        end
        if (out_v_reg && !pop && push) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {1'b0, out_reg.letter};
    assign m_tuser  = {out_reg.bad_code, out_reg.has_letter};
    assign m_tlast  = out_reg.last;

endmodule
